FILE: rtl/core/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, field widths, control codes and the forward lookup of the
// forwarding execute stage.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int unsigned DATA_WIDTH_DEFAULT = 32;

   localparam int unsigned CTRL_W  = 13;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned IMM_W   = 16;
   localparam int unsigned REGS_W  = 15;
   localparam int unsigned REG_W   = 5;
   localparam int unsigned FWD_W   = 38;
   localparam int unsigned OP_W    = 3;

   localparam int unsigned REQ_FIELDS_W = CTRL_W + 2 * VALUE_W + IMM_W + REGS_W + 4 * FWD_W;
   localparam int unsigned REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_FIELDS_W = 2 * VALUE_W + 1 + REG_W;
   localparam int unsigned RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [CTRL_W-1:0] CTRL_STORE     = 13'd72;
   localparam logic [CTRL_W-1:0] CTRL_NO_RT_FWD = 13'd2056;

   localparam int unsigned CTRL_DST_RD_BIT = 12;
   localparam int unsigned CTRL_USE_IMM_BIT = 3;
   localparam int unsigned CTRL_OP_LSB     = 8;

   localparam logic [OP_W-1:0] ALU_ADD  = 3'd0;
   localparam logic [OP_W-1:0] ALU_SUB  = 3'd2;
   localparam logic [OP_W-1:0] ALU_XOR  = 3'd4;
   localparam logic [OP_W-1:0] ALU_PASS = 3'd6;
   localparam logic [OP_W-1:0] ALU_SLT  = 3'd7;

   typedef struct packed {
      logic             wr_en;
      logic [REG_W-1:0] dest;
      logic [VALUE_W-1:0] value;
   } fwd_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] value;
   } fwd_hit_type;

   typedef struct packed {
      logic [OP_W-1:0]    alu_op;
      logic [VALUE_W-1:0] opnd_a;
      logic [VALUE_W-1:0] opnd_b;
   } alu_req_type;

   // highest priority first: exmem, mem1, mem2, wb; register zero never matches
   function automatic fwd_hit_type fwd_lookup(input logic [REG_W-1:0] reg_num,
                                              input fwd_type f_exmem,
                                              input fwd_type f_mem1,
                                              input fwd_type f_mem2,
                                              input fwd_type f_wb);
      fwd_hit_type r;
      r.hit   = 1'b0;
      r.value = '0;
      if (reg_num != '0) begin
         priority if (f_exmem.wr_en && f_exmem.dest == reg_num) begin
            r.hit   = 1'b1;
            r.value = f_exmem.value;
         end else if (f_mem1.wr_en && f_mem1.dest == reg_num) begin
            r.hit   = 1'b1;
            r.value = f_mem1.value;
         end else if (f_mem2.wr_en && f_mem2.dest == reg_num) begin
            r.hit   = 1'b1;
            r.value = f_mem2.value;
         end else if (f_wb.wr_en && f_wb.dest == reg_num) begin
            r.hit   = 1'b1;
            r.value = f_wb.value;
         end else begin
            r.hit = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/pipeline_forwarding_alu.sv
`timescale 1ns / 1ps
// registers: a request word is captured in the input register and its result in the
// result register, which drives rsp_tvalid; a low rsp_tready holds the word in either
// throughput: one word per clock, sustained while rsp_tready stays high
// a finished word waits in the result register while the next is taken in
// reset: synchronous, active high; clears both valid flags, payload is not reset
// ----------------------------------------------------------------------------
// pipeline_forwarding_alu
// Execute stage with four-level operand forwarding and an ALU, on streaming
// request and response channels.
// ----------------------------------------------------------------------------
module pipeline_forwarding_alu #(
   parameter int unsigned DATA_WIDTH = pfa_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // control_word, reg_a_value, reg_b_value, immediate, reg_numbers,
   // fwd_exmem, fwd_mem1, fwd_mem2, fwd_wb, zero pad
   input  logic [pfa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // alu_result, zero_flag, store_data, dest_reg, zero pad
   output logic [pfa_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic                                 req_valid_ff;
   logic                                 req_valid_in;
   logic [pfa_pkg::REQ_FIELDS_W-1:0]     req_word_ff;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [pfa_pkg::RSP_TDATA_W-1:0]      rsp_word_ff;
   logic [pfa_pkg::RSP_TDATA_W-1:0]      rsp_word_in;
   logic                                 rsp_free;
   logic                                 req_take;
   logic                                 adv;

   pfa_pkg::alu_req_type                 alu_req;
   logic [pfa_pkg::VALUE_W-1:0]          alu_result;
   logic                                 zero_flag;
   logic [pfa_pkg::VALUE_W-1:0]          store_data;
   logic [pfa_pkg::REG_W-1:0]            dest_reg;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || rsp_free;
   assign req_take   = req_tvalid && req_tready;
   assign adv        = req_valid_ff && rsp_free;

   assign req_valid_in = req_take || (req_valid_ff && !rsp_free);
   assign rsp_valid_in = adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_word_ff <= req_tdata[pfa_pkg::REQ_FIELDS_W-1:0];
      end
      if (adv) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   pfa_fwd u_fwd (
      .control_word (req_word_ff[12:0]),
      .reg_a_value  (req_word_ff[44:13]),
      .reg_b_value  (req_word_ff[76:45]),
      .immediate    (req_word_ff[92:77]),
      .reg_numbers  (req_word_ff[107:93]),
      .fwd_exmem    (pfa_pkg::fwd_type'(req_word_ff[145:108])),
      .fwd_mem1     (pfa_pkg::fwd_type'(req_word_ff[183:146])),
      .fwd_mem2     (pfa_pkg::fwd_type'(req_word_ff[221:184])),
      .fwd_wb       (pfa_pkg::fwd_type'(req_word_ff[259:222])),
      .alu_req      (alu_req),
      .store_data   (store_data),
      .dest_reg     (dest_reg)
   );

   pfa_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .alu_req    (alu_req),
      .alu_result (alu_result),
      .zero_flag  (zero_flag)
   );

   assign rsp_word_in = pfa_pkg::RSP_TDATA_W'({dest_reg, store_data, zero_flag, alu_result});

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

endmodule

FILE: rtl/core/pfa_fwd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_fwd
// Operand forwarding, immediate select and destination select.
// ----------------------------------------------------------------------------
module pfa_fwd (
   input  logic [pfa_pkg::CTRL_W-1:0]  control_word,
   input  logic [pfa_pkg::VALUE_W-1:0] reg_a_value,
   input  logic [pfa_pkg::VALUE_W-1:0] reg_b_value,
   input  logic [pfa_pkg::IMM_W-1:0]   immediate,
   input  logic [pfa_pkg::REGS_W-1:0]  reg_numbers,
   input  pfa_pkg::fwd_type            fwd_exmem,
   input  pfa_pkg::fwd_type            fwd_mem1,
   input  pfa_pkg::fwd_type            fwd_mem2,
   input  pfa_pkg::fwd_type            fwd_wb,
   output pfa_pkg::alu_req_type        alu_req,
   output logic [pfa_pkg::VALUE_W-1:0] store_data,
   output logic [pfa_pkg::REG_W-1:0]   dest_reg
);

   logic [pfa_pkg::REG_W-1:0]   rs_num;
   logic [pfa_pkg::REG_W-1:0]   rt_num;
   logic [pfa_pkg::REG_W-1:0]   rd_num;
   pfa_pkg::fwd_hit_type        rs_hit;
   pfa_pkg::fwd_hit_type        rt_hit;
   logic [pfa_pkg::VALUE_W-1:0] rt_value;
   logic                        is_store;
   logic                        no_rt_fwd;

   assign rs_num = reg_numbers[14:10];
   assign rt_num = reg_numbers[9:5];
   assign rd_num = reg_numbers[4:0];

   assign rs_hit = pfa_pkg::fwd_lookup(rs_num, fwd_exmem, fwd_mem1, fwd_mem2, fwd_wb);
   assign rt_hit = pfa_pkg::fwd_lookup(rt_num, fwd_exmem, fwd_mem1, fwd_mem2, fwd_wb);

   assign is_store  = (control_word == pfa_pkg::CTRL_STORE);
   assign no_rt_fwd = (control_word == pfa_pkg::CTRL_NO_RT_FWD);

   // store word sends the rt forward to store data only
   assign rt_value   = (rt_hit.hit && !is_store && !no_rt_fwd) ? rt_hit.value : reg_b_value;
   assign store_data = (rt_hit.hit && is_store) ? rt_hit.value : reg_b_value;

   assign alu_req.alu_op = control_word[pfa_pkg::CTRL_OP_LSB +: pfa_pkg::OP_W];
   assign alu_req.opnd_a = rs_hit.hit ? rs_hit.value : reg_a_value;
   assign alu_req.opnd_b = control_word[pfa_pkg::CTRL_USE_IMM_BIT]
                           ? pfa_pkg::VALUE_W'($signed(immediate)) : rt_value;

   assign dest_reg = control_word[pfa_pkg::CTRL_DST_RD_BIT] ? rd_num : rt_num;

endmodule

FILE: rtl/core/pfa_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_alu
// Pass, add, subtract, xor and signed set-less-than at DATA_WIDTH bits.
// ----------------------------------------------------------------------------
module pfa_alu #(
   parameter int unsigned DATA_WIDTH = pfa_pkg::DATA_WIDTH_DEFAULT
) (
   input  pfa_pkg::alu_req_type        alu_req,
   output logic [pfa_pkg::VALUE_W-1:0] alu_result,
   output logic                        zero_flag
);

   logic [DATA_WIDTH-1:0] a_w;
   logic [DATA_WIDTH-1:0] b_w;
   logic [DATA_WIDTH-1:0] res;

   // operands are 32-bit signed words, extended or cut to the alu width
   assign a_w = DATA_WIDTH'($signed(alu_req.opnd_a));
   assign b_w = DATA_WIDTH'($signed(alu_req.opnd_b));

   always_comb begin
      unique case (alu_req.alu_op)
         pfa_pkg::ALU_ADD:  res = a_w + b_w;
         pfa_pkg::ALU_SUB:  res = a_w - b_w;
         pfa_pkg::ALU_XOR:  res = a_w ^ b_w;
         pfa_pkg::ALU_PASS: res = a_w;
         pfa_pkg::ALU_SLT:  res = DATA_WIDTH'($signed(a_w) < $signed(b_w));
         default:           res = '0;
      endcase
   end

   assign alu_result = pfa_pkg::VALUE_W'(res);
   assign zero_flag  = (res == '0);

endmodule

FILE: rtl/core/pfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks of the forwarding execute stage, bound to the top level.
// ----------------------------------------------------------------------------
module pfa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [pfa_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pfa_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic req_tdata_seen;

   assign req_tdata_seen = ^req_tdata;

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

   // zero flag only with a zero result
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0)
      else $error("zero flag with nonzero result");

   // rsp_tvalid must follow an accepted word once rsp_tready has been high after it
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata_seen || !req_tdata_seen)) ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("response missing after accepted request");

endmodule

bind pipeline_forwarding_alu pfa_checker u_pfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/sv/tb_pipeline_forwarding_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pipeline_forwarding_alu
// Self-checking bench for the forwarding execute stage. Instruction words are
// queued up front and fed in bursts on the request stream. Each accepted word
// is run through a local model of the forwarding mux and the ALU. Every
// response word is checked field by field against the oldest prediction,
// while the response side is stalled on a changing pattern.
// ----------------------------------------------------------------------------
module tb_pipeline_forwarding_alu;

   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned RANDOM_WORDS = 1080;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned TAIL_CYCLES  = 8;

   // alu op codes with no defined operation
   localparam logic [pfa_pkg::OP_W-1:0] ALU_RSVD_1 = 3'd1;
   localparam logic [pfa_pkg::OP_W-1:0] ALU_RSVD_3 = 3'd3;
   localparam logic [pfa_pkg::OP_W-1:0] ALU_RSVD_5 = 3'd5;

   // lowest field last in the declaration, so it lands in the lowest bits
   typedef struct packed {
      logic [pfa_pkg::REQ_TDATA_W-pfa_pkg::REQ_FIELDS_W-1:0] pad;
      pfa_pkg::fwd_type                                      fwd_wb;
      pfa_pkg::fwd_type                                      fwd_mem2;
      pfa_pkg::fwd_type                                      fwd_mem1;
      pfa_pkg::fwd_type                                      fwd_exmem;
      logic [pfa_pkg::REGS_W-1:0]                            regs;
      logic [pfa_pkg::IMM_W-1:0]                             imm;
      logic [pfa_pkg::VALUE_W-1:0]                           rt_value;
      logic [pfa_pkg::VALUE_W-1:0]                           rs_value;
      logic [pfa_pkg::CTRL_W-1:0]                            ctrl;
   } instr_word_type;

   typedef struct packed {
      logic [pfa_pkg::RSP_TDATA_W-pfa_pkg::RSP_FIELDS_W-1:0] pad;
      logic [pfa_pkg::REG_W-1:0]                             dest_reg;
      logic [pfa_pkg::VALUE_W-1:0]                           store_data;
      logic                                                  zero_flag;
      logic [pfa_pkg::VALUE_W-1:0]                           alu_result;
   } exec_result_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC,
      READY_BURSTY
   } ready_mode_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   instr_word_type  req_tdata = '0;  // ctrl, rs value, rt value, imm, regs, exmem, mem1, mem2, wb, pad
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   exec_result_type rsp_tdata;       // alu_result, zero_flag, store_data, dest_reg, pad

   instr_word_type  instr_q[$];
   exec_result_type exec_results_q[$];

   logic            req_fire = 1'b0;
   int unsigned     gap_left = 0;
   int unsigned     burst_left = 0;
   ready_mode_type  ready_mode = READY_ALWAYS;
   int unsigned     mode_left = 0;
   int unsigned     hold_left = 0;
   int unsigned     pattern_step = 0;

   int unsigned     mismatch_count = 0;
   int unsigned     words_sent = 0;
   int unsigned     results_checked = 0;
   int unsigned     store_words = 0;
   int unsigned     no_rt_fwd_words = 0;
   int unsigned     stall_cycles = 0;
   int unsigned     idle_cycles = 0;
   exec_result_type want;
   exec_result_type got;

   pipeline_forwarding_alu DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // highest priority stage wins, register zero never matches
   function automatic logic [pfa_pkg::VALUE_W:0] forward_value(
         input logic [pfa_pkg::REG_W-1:0] rnum,
         input instr_word_type w);
      pfa_pkg::fwd_type          stage[4];
      logic [pfa_pkg::VALUE_W:0] found;
      stage[0] = w.fwd_exmem;
      stage[1] = w.fwd_mem1;
      stage[2] = w.fwd_mem2;
      stage[3] = w.fwd_wb;
      found = '0;
      for (int i = 3; i >= 0; i--) begin
         if (rnum != '0 && stage[i].wr_en && stage[i].dest == rnum) begin
            found = {1'b1, stage[i].value};
         end
      end
      return found;
   endfunction

   function automatic exec_result_type execute_predict(input instr_word_type w);
      exec_result_type             r;
      logic [pfa_pkg::OP_W-1:0]    op;
      logic [pfa_pkg::REG_W-1:0]   rs, rt, rd;
      logic [pfa_pkg::VALUE_W-1:0] opa, rtv, opb, imm_x;
      logic [pfa_pkg::VALUE_W:0]   hit_s, hit_t;
      r   = '0;
      op  = w.ctrl[pfa_pkg::CTRL_OP_LSB +: pfa_pkg::OP_W];
      rs  = w.regs[2*pfa_pkg::REG_W +: pfa_pkg::REG_W];
      rt  = w.regs[pfa_pkg::REG_W +: pfa_pkg::REG_W];
      rd  = w.regs[0 +: pfa_pkg::REG_W];
      hit_s = forward_value(rs, w);
      hit_t = forward_value(rt, w);
      opa = hit_s[pfa_pkg::VALUE_W] ? hit_s[pfa_pkg::VALUE_W-1:0] : w.rs_value;
      rtv = w.rt_value;
      r.store_data = w.rt_value;
      if (w.ctrl == pfa_pkg::CTRL_STORE) begin
         if (hit_t[pfa_pkg::VALUE_W]) r.store_data = hit_t[pfa_pkg::VALUE_W-1:0];
      end else if (w.ctrl != pfa_pkg::CTRL_NO_RT_FWD && hit_t[pfa_pkg::VALUE_W]) begin
         rtv = hit_t[pfa_pkg::VALUE_W-1:0];
      end
      imm_x = {{(pfa_pkg::VALUE_W-pfa_pkg::IMM_W){w.imm[pfa_pkg::IMM_W-1]}}, w.imm};
      opb = w.ctrl[pfa_pkg::CTRL_USE_IMM_BIT] ? imm_x : rtv;
      case (op)
         pfa_pkg::ALU_ADD:  r.alu_result = opa + opb;
         pfa_pkg::ALU_SUB:  r.alu_result = opa - opb;
         pfa_pkg::ALU_XOR:  r.alu_result = opa ^ opb;
         pfa_pkg::ALU_PASS: r.alu_result = opa;
         pfa_pkg::ALU_SLT:
            r.alu_result = ($signed(opa) < $signed(opb)) ? pfa_pkg::VALUE_W'(1) : '0;
         default:           r.alu_result = '0;
      endcase
      r.zero_flag = (r.alu_result == '0);
      r.dest_reg  = w.ctrl[pfa_pkg::CTRL_DST_RD_BIT] ? rd : rt;
      return r;
   endfunction

   function automatic logic [pfa_pkg::CTRL_W-1:0] ctrl_of(input logic [pfa_pkg::OP_W-1:0] op,
                                                          input logic use_imm,
                                                          input logic dst_rd);
      logic [pfa_pkg::CTRL_W-1:0] c;
      c = '0;
      c[pfa_pkg::CTRL_OP_LSB +: pfa_pkg::OP_W] = op;
      c[pfa_pkg::CTRL_USE_IMM_BIT]             = use_imm;
      c[pfa_pkg::CTRL_DST_RD_BIT]              = dst_rd;
      return c;
   endfunction

   function automatic instr_word_type make_word(input logic [pfa_pkg::CTRL_W-1:0] ctrl,
                                                input logic [pfa_pkg::VALUE_W-1:0] a,
                                                input logic [pfa_pkg::VALUE_W-1:0] b,
                                                input logic [pfa_pkg::IMM_W-1:0] imm,
                                                input logic [pfa_pkg::REG_W-1:0] rs,
                                                input logic [pfa_pkg::REG_W-1:0] rt,
                                                input logic [pfa_pkg::REG_W-1:0] rd);
      instr_word_type w;
      w = '0;
      w.ctrl     = ctrl;
      w.rs_value = a;
      w.rt_value = b;
      w.imm      = imm;
      w.regs     = {rs, rt, rd};
      return w;
   endfunction

   function automatic pfa_pkg::fwd_type fwd_of(input logic wr,
                                               input logic [pfa_pkg::REG_W-1:0] dest,
                                               input logic [pfa_pkg::VALUE_W-1:0] value);
      pfa_pkg::fwd_type f;
      f.wr_en = wr;
      f.dest  = dest;
      f.value = value;
      return f;
   endfunction

   function automatic logic [pfa_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return {1'b0, {(pfa_pkg::VALUE_W-1){1'b1}}};
         2:       return {1'b1, {(pfa_pkg::VALUE_W-1){1'b0}}};
         3:       return '1;
         4:       return pfa_pkg::VALUE_W'($urandom_range(0, 3));
         default: return pfa_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   // half of the forwards aim at rs or rt so the priority chain gets exercised
   function automatic pfa_pkg::fwd_type random_fwd(input logic [pfa_pkg::REG_W-1:0] rs,
                                                   input logic [pfa_pkg::REG_W-1:0] rt);
      pfa_pkg::fwd_type f;
      f.wr_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
         0:       f.dest = rs;
         1:       f.dest = rt;
         default: f.dest = pfa_pkg::REG_W'($urandom);
      endcase
      f.value = random_value();
      return f;
   endfunction

   function automatic instr_word_type random_word();
      instr_word_type             w;
      logic [pfa_pkg::CTRL_W-1:0] c;
      logic [pfa_pkg::REG_W-1:0]  rs, rt;
      int unsigned                pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) c = pfa_pkg::CTRL_STORE;
      else if (pick < 20) c = pfa_pkg::CTRL_NO_RT_FWD;
      else c = pfa_pkg::CTRL_W'($urandom);
      rs = pfa_pkg::REG_W'($urandom);
      rt = pfa_pkg::REG_W'($urandom);
      w = make_word(c, random_value(), random_value(), pfa_pkg::IMM_W'($urandom), rs, rt,
                    pfa_pkg::REG_W'($urandom));
      w.fwd_exmem = random_fwd(rs, rt);
      w.fwd_mem1  = random_fwd(rs, rt);
      w.fwd_mem2  = random_fwd(rs, rt);
      w.fwd_wb    = random_fwd(rs, rt);
      return w;
   endfunction

   task automatic check_field(input string name, input logic [pfa_pkg::VALUE_W-1:0] exp_v,
                              input logic [pfa_pkg::VALUE_W-1:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     results_checked, name, exp_v, act_v);
      end
   endtask

   // request driver, bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (instr_q.size() != 0) begin
            req_tdata  <= instr_q.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response backpressure in one of four ready modes, picked anew at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: begin
               pattern_step++;
               rsp_tready <= (pattern_step % 4) != 3;
            end
            default: begin
               if (hold_left != 0) begin
                  hold_left--;
                  rsp_tready <= 1'b0;
               end else if ($urandom_range(0, 15) == 0) begin
                  hold_left = $urandom_range(5, 30);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && !rsp_tready) stall_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (exec_results_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result word %h", got);
            end else begin
               want = exec_results_q.pop_front();
               check_field("alu_result", want.alu_result, got.alu_result);
               check_field("zero_flag", pfa_pkg::VALUE_W'(want.zero_flag),
                           pfa_pkg::VALUE_W'(got.zero_flag));
               check_field("store_data", want.store_data, got.store_data);
               check_field("dest_reg", pfa_pkg::VALUE_W'(want.dest_reg),
                           pfa_pkg::VALUE_W'(got.dest_reg));
            end
            results_checked++;
         end
         if (req_tvalid && req_tready) begin
            exec_results_q.push_back(execute_predict(req_tdata));
            words_sent++;
            if (req_tdata.ctrl == pfa_pkg::CTRL_STORE) store_words++;
            if (req_tdata.ctrl == pfa_pkg::CTRL_NO_RT_FWD) no_rt_fwd_words++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("no word moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, exec_results_q.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      instr_word_type              w;
      logic [pfa_pkg::VALUE_W-1:0] max_v, min_v;
      max_v = {1'b0, {(pfa_pkg::VALUE_W-1){1'b1}}};
      min_v = {1'b1, {(pfa_pkg::VALUE_W-1){1'b0}}};

      // alu ops and wrap points, no forwarding
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_ADD, 1'b0, 1'b1), max_v, 32'd1,
                                  16'd0, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_SUB, 1'b0, 1'b0), min_v, 32'd1,
                                  16'd0, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_SUB, 1'b0, 1'b1), 32'h1234, 32'h1234,
                                  16'd0, 5'd4, 5'd5, 5'd6));
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_XOR, 1'b0, 1'b1), '1, 32'h55555555,
                                  16'd0, 5'd7, 5'd8, 5'd9));
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_PASS, 1'b0, 1'b0), 32'h12345678, '0,
                                  16'd0, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_SLT, 1'b0, 1'b1), min_v, max_v,
                                  16'd0, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_SLT, 1'b0, 1'b1), max_v, min_v,
                                  16'd0, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_SLT, 1'b0, 1'b1), '1, '0,
                                  16'd0, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_SLT, 1'b0, 1'b1), 32'd7, 32'd7,
                                  16'd0, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word(ctrl_of(ALU_RSVD_1, 1'b0, 1'b1), 32'd5, 32'd9,
                                  16'd0, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word(ctrl_of(ALU_RSVD_3, 1'b0, 1'b1), 32'd5, 32'd9,
                                  16'd0, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word(ctrl_of(ALU_RSVD_5, 1'b1, 1'b1), 32'd5, 32'd9,
                                  16'd0, 5'd1, 5'd2, 5'd3));
      // immediate extremes
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_ADD, 1'b1, 1'b0), 32'd3, 32'd99,
                                  16'h8000, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word(ctrl_of(pfa_pkg::ALU_SUB, 1'b1, 1'b1), 32'd3, 32'd99,
                                  16'h7fff, 5'd1, 5'd2, 5'd3));
      instr_q.push_back(make_word('1, min_v, '0, 16'h8000, 5'd31, 5'd31, 5'd31));
      instr_q.push_back(make_word('0, '0, '0, '0, '0, '0, '0));

      // all four stages hit rs, execute/memory wins
      w = make_word(ctrl_of(pfa_pkg::ALU_PASS, 1'b0, 1'b1), 32'h11, 32'h22, 16'd0,
                    5'd5, 5'd6, 5'd7);
      w.fwd_exmem = fwd_of(1'b1, 5'd5, 32'hA0A0A0A0);
      w.fwd_mem1  = fwd_of(1'b1, 5'd5, 32'hB1B1B1B1);
      w.fwd_mem2  = fwd_of(1'b1, 5'd5, 32'hC2C2C2C2);
      w.fwd_wb    = fwd_of(1'b1, 5'd5, 32'hD3D3D3D3);
      instr_q.push_back(w);
      // disabled higher stage, memory-2 wins for rs, memory-1 feeds rt
      w = make_word(ctrl_of(pfa_pkg::ALU_ADD, 1'b0, 1'b1), 32'h11, 32'h22, 16'd0,
                    5'd5, 5'd6, 5'd7);
      w.fwd_exmem = fwd_of(1'b0, 5'd5, 32'hA0A0A0A0);
      w.fwd_mem1  = fwd_of(1'b1, 5'd6, 32'h00000100);
      w.fwd_mem2  = fwd_of(1'b1, 5'd5, 32'h00001000);
      w.fwd_wb    = fwd_of(1'b1, 5'd5, 32'hD3D3D3D3);
      instr_q.push_back(w);
      // register zero never forwards
      w = make_word(ctrl_of(pfa_pkg::ALU_ADD, 1'b0, 1'b0), 32'h40, 32'h2, 16'd0,
                    5'd0, 5'd0, 5'd9);
      w.fwd_exmem = fwd_of(1'b1, 5'd0, 32'hFFFF0000);
      w.fwd_mem1  = fwd_of(1'b1, 5'd0, 32'h0000FFFF);
      w.fwd_mem2  = fwd_of(1'b1, 5'd0, 32'h12121212);
      w.fwd_wb    = fwd_of(1'b1, 5'd0, 32'h34343434);
      instr_q.push_back(w);
      // store word, rt forward goes to store data
      w = make_word(pfa_pkg::CTRL_STORE, 32'h100, 32'h200, 16'h0004, 5'd3, 5'd9, 5'd12);
      w.fwd_exmem = fwd_of(1'b1, 5'd3, 32'h1000);
      w.fwd_wb    = fwd_of(1'b1, 5'd9, 32'hCAFE0001);
      instr_q.push_back(w);
      // no rt forwarding word
      w = make_word(pfa_pkg::CTRL_NO_RT_FWD, 32'h100, 32'h200, 16'h0004, 5'd3, 5'd9, 5'd12);
      w.fwd_mem1 = fwd_of(1'b1, 5'd3, 32'h1000);
      w.fwd_mem2 = fwd_of(1'b1, 5'd9, 32'hCAFE0002);
      instr_q.push_back(w);
      // immediate overrides a forwarded rt
      w = make_word(ctrl_of(pfa_pkg::ALU_ADD, 1'b1, 1'b1), 32'h10, 32'h20, 16'hFFFF,
                    5'd4, 5'd8, 5'd12);
      w.fwd_exmem = fwd_of(1'b1, 5'd8, 32'h77777777);
      instr_q.push_back(w);
      // writeback alone feeds rt
      w = make_word(ctrl_of(pfa_pkg::ALU_SUB, 1'b0, 1'b0), 32'h10, 32'h20, 16'd0,
                    5'd4, 5'd8, 5'd12);
      w.fwd_wb = fwd_of(1'b1, 5'd8, 32'h3);
      instr_q.push_back(w);
      // every field bit set, pad cleared
      w = '0;
      w = ~w;
      w.pad = '0;
      instr_q.push_back(w);

      for (int i = 0; i < RANDOM_WORDS; i++) instr_q.push_back(random_word());

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (instr_q.size() != 0 || req_tvalid) @(posedge clock);
      while (exec_results_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d words (%0d store, %0d without rt forwarding), checked %0d results",
               words_sent, store_words, no_rt_fwd_words, results_checked);
      $display("response side stalled on %0d cycles, %0d mismatches",
               stall_cycles, mismatch_count);
      if (mismatch_count == 0 && exec_results_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
